// ===== hw/rtl/wsp_pkg.sv =====
// Shared constants, codes and the sequencer state type of the shortest path engine.
package wsp_pkg;

    // Default sizes of the stores.
    localparam int NodeCountDef    = 64;
    localparam int EdgeCapacityDef = 1024;
    localparam int WavelengthsDef  = 64;

    // Fixed field widths of the ports.
    localparam int CmdW    = 3;
    localparam int NodeW   = 6;
    localparam int WeightW = 16;
    localparam int WlW     = 6;
    localparam int ModeW   = 2;
    localparam int PairW   = 9;
    localparam int StatusW = 3;
    localparam int IndexW  = 10;

    // Path limits and the unreached distance mark.
    localparam int          PathCntW      = 6;
    localparam int          PathDepth     = 64;
    localparam logic [5:0]  PathMaxEdges  = 6'd63;
    localparam logic [31:0] DistInf       = 32'h3f3f3f3f;

    // Command codes.
    localparam logic [CmdW-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CmdW-1:0] CMD_ADD     = 3'd1;
    localparam logic [CmdW-1:0] CMD_OCCUPY  = 3'd2;
    localparam logic [CmdW-1:0] CMD_RELEASE = 3'd3;
    localparam logic [CmdW-1:0] CMD_QUERY   = 3'd4;

    // Result status codes.
    localparam logic [StatusW-1:0] ST_PATH_EDGE  = 3'd0;
    localparam logic [StatusW-1:0] ST_NO_PATH    = 3'd1;
    localparam logic [StatusW-1:0] ST_STORE_FULL = 3'd2;
    localparam logic [StatusW-1:0] ST_EMPTY_PATH = 3'd3;
    localparam logic [StatusW-1:0] ST_PAIR_ADDED = 3'd4;

    // Weight modes.
    localparam logic [ModeW-1:0] MODE_REAL  = 2'd0;
    localparam logic [ModeW-1:0] MODE_COMPL = 2'd1;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_A_RD,
        S_ADD_A_WR,
        S_ADD_B_RD,
        S_ADD_B_WR,
        S_OCC_RD,
        S_OCC_WR,
        S_RESP,
        S_Q_INIT,
        S_Q_POP,
        S_Q_HEAD,
        S_Q_HEADW,
        S_Q_EDGE,
        S_Q_EDGEW,
        S_Q_RELAX,
        S_Q_DONE,
        S_P_PRED,
        S_P_FROM,
        S_P_NEXT,
        S_E_RD,
        S_E_SEND
    } state_t;

endpackage

// ===== hw/rtl/wsp_edge_mem.sv =====
// Edge record store and per-pair wavelength occupancy store, each with a registered read.
module wsp_edge_mem
    import wsp_pkg::*;
#(
    parameter int EdgeW = 10,
    parameter int PairAw = 9,
    parameter int RecW = 39,
    parameter int Wavelengths = WavelengthsDef
)
(
    input  logic                   clk,
    input  logic                   edge_we,
    input  logic [EdgeW-1:0]       edge_waddr,
    input  logic [RecW-1:0]        edge_wdata,
    input  logic [EdgeW-1:0]       edge_raddr,
    output logic [RecW-1:0]        edge_rdata,
    input  logic                   mask_we,
    input  logic [PairAw-1:0]      mask_waddr,
    input  logic [Wavelengths-1:0] mask_wdata,
    input  logic [PairAw-1:0]      mask_raddr,
    output logic [Wavelengths-1:0] mask_rdata
);

    logic [RecW-1:0]        edge_mem [2**EdgeW];
    logic [Wavelengths-1:0] mask_mem [2**PairAw];

    // Edge records.
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        edge_rdata <= edge_mem[edge_raddr];
    end

    // Occupancy masks.
    always_ff @(posedge clk)
    begin
        if (mask_we)
        begin
            mask_mem[mask_waddr] <= mask_wdata;
        end
        mask_rdata <= mask_mem[mask_raddr];
    end

endmodule

// ===== hw/rtl/wavelength_shortest_path.sv =====
// Top level of the wavelength-aware shortest path engine with its command sequencer.
//
// Commands enter on the input channel (in_valid / in_stall) one at a time; in_stall is
// high from the transfer until the command is finished. Results leave through an output
// register on the output channel (out_valid / out_stall); a new command is taken while
// the last result of the previous one still waits there. Clear is done at the transfer;
// occupy and release read and then write the pair's mask (nothing if the pair or the
// wavelength is out of range); an add reads and writes the head of each end in turn
// and then sends its result. A query runs a FIFO-queue relaxation, reading the head and
// distance of each node taken from the queue and the record and far-end distance of
// each adjacency edge, then traces the path back through the predecessors and emits its
// edges. Each store (edge records, distances, queue) has a single read port, read one
// word a cycle with a registered read. Reset empties all adjacency lists, zeroes the
// edge count and max_weight, and drops any waiting result. While a result waits and
// out_stall is high, the sequencer holds at its next result and no result is lost.
// The user writes max_weight by cfg_write with cfg_data while idle; no check enforces it.
module wavelength_shortest_path
    import wsp_pkg::*;
#(
    parameter int NODE_COUNT    = NodeCountDef,
    parameter int EDGE_CAPACITY = EdgeCapacityDef,
    parameter int WAVELENGTHS   = WavelengthsDef
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [WeightW-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CmdW-1:0]    cmd,
    input  logic [NodeW-1:0]   node_a,
    input  logic [NodeW-1:0]   node_b,
    input  logic [WeightW-1:0] edge_weight,
    input  logic [WlW-1:0]     wavelength,
    input  logic [ModeW-1:0]   weight_mode,
    input  logic [PairW-1:0]   edge_pair,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [StatusW-1:0] status,
    output logic [IndexW-1:0]  edge_index,
    output logic               last
);

    localparam int NW    = $clog2(NODE_COUNT);
    localparam int EW    = $clog2(EDGE_CAPACITY);
    localparam int ECW   = EW + 1;
    localparam int PW    = (EW > 1) ? EW - 1 : 1;
    localparam int RECW  = 2 * NW + WeightW + EW + 1;
    localparam int NXT_L = 1;
    localparam int WT_L  = EW + 1;
    localparam int TO_L  = EW + WeightW + 1;
    localparam int FR_L  = EW + WeightW + NW + 1;
    localparam logic [WAVELENGTHS-1:0] OneWl = 1;
    localparam logic [NODE_COUNT-1:0]  OneNode = 1;

    // Sequencer and graph control state.
    state_t state_reg, state_next;
    logic [ECW-1:0]        ec_reg;
    logic [NODE_COUNT-1:0] hvalid_reg;
    logic [NODE_COUNT-1:0] inq_reg;
    logic [NODE_COUNT-1:0] dvalid_reg;
    logic [WeightW-1:0]    max_weight_reg;

    // Latched command fields.
    logic [NW-1:0]          na_reg, nb_reg;
    logic [WeightW-1:0]     w_reg;
    logic [WAVELENGTHS-1:0] bit_reg;
    logic                   use_mask_reg;
    logic [ModeW-1:0]       mode_reg;
    logic [PW-1:0]          pair_reg;
    logic                   occ_set_reg;

    // Search registers.
    logic [NW-1:0]  front_reg, tail_reg, u_reg, to_reg, n_reg;
    logic [NW:0]    size_reg;
    logic [31:0]    du_reg, nd_reg;
    logic [EW-1:0]  e_reg, next_reg;
    logic           more_reg, nv_reg, ok_reg;
    logic [PathCntW-1:0] cnt_reg, i_reg;

    // Single-result and output registers.
    logic [StatusW-1:0] resp_status_reg;
    logic [IndexW-1:0]  resp_index_reg;
    logic               out_valid_reg;
    logic [StatusW-1:0] status_reg;
    logic [IndexW-1:0]  edge_index_reg;
    logic               last_reg;

    // Local memories.
    logic [EW-1:0]  head_mem [2**NW];
    logic [31:0]    dist_mem [2**NW];
    logic [EW-1:0]  pred_mem [2**NW];
    logic [NW-1:0]  queue_mem [2**NW];
    logic [EW-1:0]  path_mem [PathDepth];
    logic [EW-1:0]  head_rdata, pred_rdata, path_rdata;
    logic [31:0]    dist_rdata;
    logic [NW-1:0]  queue_rdata;

    // Memory controls.
    logic           head_we, dist_we, pred_we, queue_we, path_we;
    logic [NW-1:0]  head_waddr, head_raddr, dist_waddr, dist_raddr;
    logic [EW-1:0]  head_wdata, pred_wdata;
    logic [31:0]    dist_wdata;
    logic           edge_we, mask_we;
    logic [EW-1:0]  edge_waddr, edge_raddr;
    logic [RECW-1:0] edge_wdata, edge_rdata;
    logic [PW-1:0]  mask_waddr, mask_raddr;
    logic [WAVELENGTHS-1:0] mask_wdata, mask_rdata;

    // Decoded values.
    logic           in_xfer, out_free, load_out;
    logic           a_bad, b_bad, full;
    logic [NW-1:0]  rd_from, rd_to, n_step;
    logic [WeightW-1:0] rd_weight;
    logic [EW-1:0]  rd_next;
    logic           rd_nv;
    logic [16:0]    cost;
    logic [31:0]    cur_dist;
    logic           relax;
    logic           edge_live, pred_live;
    logic [PathCntW-1:0] cnt_inc;
    logic [StatusW-1:0]  load_status;
    logic [IndexW-1:0]   load_index;
    logic                load_last;

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign a_bad    = 32'(node_a) >= NODE_COUNT;
    assign b_bad    = 32'(node_b) >= NODE_COUNT;
    assign full     = 32'(ec_reg) + 32'd2 > EDGE_CAPACITY;

    // Edge record fields.
    assign rd_nv     = edge_rdata[0];
    assign rd_next   = edge_rdata[WT_L-1:NXT_L];
    assign rd_weight = edge_rdata[TO_L-1:WT_L];
    assign rd_to     = edge_rdata[FR_L-1:TO_L];
    assign rd_from   = edge_rdata[RECW-1:FR_L];

    // Edge cost by weight mode.
    always_comb
    begin
        if (mode_reg == MODE_REAL)
        begin
            cost = {1'b0, rd_weight};
        end
        else if (mode_reg == MODE_COMPL)
        begin
            cost = (max_weight_reg > rd_weight) ? {1'b0, max_weight_reg - rd_weight} : 17'd0;
        end
        else
        begin
            cost = 17'd1;
        end
    end

    assign cur_dist  = dvalid_reg[to_reg] ? dist_rdata : DistInf;
    assign relax     = ok_reg && (cur_dist > nd_reg);
    assign edge_live = more_reg && ({1'b0, e_reg} < ec_reg);
    assign pred_live = {1'b0, pred_rdata} < ec_reg;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign n_step    = pred_live ? n_reg : na_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (cmd)
                        CMD_ADD:
                        begin
                            state_next = (a_bad || b_bad || full) ? S_RESP : S_ADD_A_RD;
                        end
                        CMD_OCCUPY, CMD_RELEASE:
                        begin
                            if ((32'(edge_pair) < 32'(ec_reg >> 1)) &&
                                (32'(wavelength) < WAVELENGTHS))
                            begin
                                state_next = S_OCC_RD;
                            end
                        end
                        CMD_QUERY:
                        begin
                            state_next = (a_bad || b_bad) ? S_RESP : S_Q_INIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_A_RD: state_next = S_ADD_A_WR;
            S_ADD_A_WR: state_next = S_ADD_B_RD;
            S_ADD_B_RD: state_next = S_ADD_B_WR;
            S_ADD_B_WR: state_next = S_RESP;
            S_OCC_RD:   state_next = S_OCC_WR;
            S_OCC_WR:   state_next = S_IDLE;
            S_RESP:     state_next = out_free ? S_IDLE : S_RESP;
            S_Q_INIT:   state_next = S_Q_POP;
            S_Q_POP:    state_next = (size_reg == '0) ? S_Q_DONE : S_Q_HEAD;
            S_Q_HEAD:   state_next = S_Q_HEADW;
            S_Q_HEADW:  state_next = S_Q_EDGE;
            S_Q_EDGE:   state_next = edge_live ? S_Q_EDGEW : S_Q_POP;
            S_Q_EDGEW:  state_next = S_Q_RELAX;
            S_Q_RELAX:  state_next = S_Q_EDGE;
            S_Q_DONE:
            begin
                if (!dvalid_reg[nb_reg] || (na_reg == nb_reg))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_P_PRED;
                end
            end
            S_P_PRED:   state_next = S_P_FROM;
            S_P_FROM:
            begin
                if (pred_live)
                begin
                    state_next = S_P_NEXT;
                end
                else
                begin
                    state_next = S_E_RD;
                end
            end
            S_P_NEXT:
            begin
                if ((rd_from != na_reg) && (cnt_reg < PathMaxEdges))
                begin
                    state_next = S_P_PRED;
                end
                else
                begin
                    state_next = S_E_RD;
                end
            end
            S_E_RD:     state_next = S_E_SEND;
            S_E_SEND:
            begin
                if (out_free)
                begin
                    state_next = (i_reg + 1'b1 == cnt_reg) ? S_IDLE : S_E_RD;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Memory strobes, addresses and the output load.
    always_comb
    begin
        head_we     = 1'b0;
        head_waddr  = na_reg;
        head_wdata  = ec_reg[EW-1:0];
        head_raddr  = na_reg;
        dist_we     = 1'b0;
        dist_waddr  = to_reg;
        dist_wdata  = nd_reg;
        dist_raddr  = u_reg;
        pred_we     = 1'b0;
        pred_wdata  = e_reg;
        queue_we    = 1'b0;
        path_we     = 1'b0;
        edge_we     = 1'b0;
        edge_waddr  = ec_reg[EW-1:0];
        edge_wdata  = {na_reg, nb_reg, w_reg, head_rdata, hvalid_reg[na_reg]};
        edge_raddr  = e_reg;
        mask_we     = 1'b0;
        mask_waddr  = PW'(ec_reg >> 1);
        mask_wdata  = '0;
        mask_raddr  = PW'(e_reg >> 1);
        load_out    = 1'b0;
        load_status = resp_status_reg;
        load_index  = resp_index_reg;
        load_last   = 1'b1;
        unique case (state_reg)
            S_ADD_A_WR:
            begin
                edge_we = 1'b1;
                head_we = 1'b1;
                mask_we = 1'b1;
            end
            S_ADD_B_RD:
            begin
                head_raddr = nb_reg;
            end
            S_ADD_B_WR:
            begin
                edge_we    = 1'b1;
                edge_wdata = {nb_reg, na_reg, w_reg, head_rdata, hvalid_reg[nb_reg]};
                head_we    = 1'b1;
                head_waddr = nb_reg;
            end
            S_OCC_RD:
            begin
                mask_raddr = pair_reg;
            end
            S_OCC_WR:
            begin
                mask_we    = 1'b1;
                mask_waddr = pair_reg;
                mask_wdata = occ_set_reg ? (mask_rdata | bit_reg) : (mask_rdata & ~bit_reg);
            end
            S_RESP:
            begin
                load_out = out_free;
            end
            S_Q_INIT:
            begin
                dist_we    = 1'b1;
                dist_waddr = na_reg;
                dist_wdata = '0;
                queue_we   = 1'b1;
            end
            S_Q_HEAD:
            begin
                head_raddr = queue_rdata;
                dist_raddr = queue_rdata;
            end
            S_Q_EDGEW:
            begin
                dist_raddr = rd_to;
            end
            S_Q_RELAX:
            begin
                dist_we  = relax;
                pred_we  = relax;
                queue_we = relax && !inq_reg[to_reg];
            end
            S_P_FROM:
            begin
                path_we    = 1'b1;
                edge_raddr = pred_rdata;
            end
            S_E_SEND:
            begin
                load_out    = out_free;
                load_status = ST_PATH_EDGE;
                load_index  = IndexW'(path_rdata);
                load_last   = (i_reg + 1'b1 == cnt_reg);
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    // Adjacency heads, distances, predecessors, queue and path buffer.
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        if (pred_we)
        begin
            pred_mem[to_reg] <= pred_wdata;
        end
        // The source node goes into the first queue slot when a query starts.
        if (queue_we)
        begin
            queue_mem[(state_reg == S_Q_INIT) ? NW'(0) : tail_reg] <=
                (state_reg == S_Q_INIT) ? na_reg : to_reg;
        end
        if (path_we)
        begin
            path_mem[cnt_reg] <= pred_rdata;
        end
        head_rdata  <= head_mem[head_raddr];
        dist_rdata  <= dist_mem[dist_raddr];
        pred_rdata  <= pred_mem[n_reg];
        queue_rdata <= queue_mem[front_reg];
        path_rdata  <= path_mem[cnt_reg - 1'b1 - i_reg];
    end

    wsp_edge_mem #(
        .EdgeW       (EW),
        .PairAw      (PW),
        .RecW        (RECW),
        .Wavelengths (WAVELENGTHS)
    ) u_edge_mem (
        .clk        (clk),
        .edge_we    (edge_we),
        .edge_waddr (edge_waddr),
        .edge_wdata (edge_wdata),
        .edge_raddr (edge_raddr),
        .edge_rdata (edge_rdata),
        .mask_we    (mask_we),
        .mask_waddr (mask_waddr),
        .mask_wdata (mask_wdata),
        .mask_raddr (mask_raddr),
        .mask_rdata (mask_rdata)
    );

    // Control state: sequencer, graph bookkeeping and search flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ec_reg         <= '0;
            hvalid_reg     <= '0;
            inq_reg        <= '0;
            dvalid_reg     <= '0;
            max_weight_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                max_weight_reg <= cfg_data;
            end
            if (in_xfer && (cmd == CMD_CLEAR))
            begin
                hvalid_reg <= '0;
                ec_reg     <= '0;
            end
            if (state_reg == S_ADD_A_WR)
            begin
                hvalid_reg[na_reg] <= 1'b1;
                ec_reg             <= ec_reg + 1'b1;
            end
            if (state_reg == S_ADD_B_WR)
            begin
                hvalid_reg[nb_reg] <= 1'b1;
                ec_reg             <= ec_reg + 1'b1;
            end
            if (state_reg == S_Q_INIT)
            begin
                inq_reg    <= OneNode << na_reg;
                dvalid_reg <= OneNode << na_reg;
            end
            if (state_reg == S_Q_HEAD)
            begin
                inq_reg[queue_rdata] <= 1'b0;
            end
            if ((state_reg == S_Q_RELAX) && relax)
            begin
                dvalid_reg[to_reg] <= 1'b1;
                inq_reg[to_reg]    <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the command, the search and the output.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            na_reg          <= NW'(node_a);
            nb_reg          <= NW'(node_b);
            w_reg           <= edge_weight;
            mode_reg        <= weight_mode;
            pair_reg        <= PW'(edge_pair);
            occ_set_reg     <= (cmd == CMD_OCCUPY);
            bit_reg         <= OneWl << wavelength;
            use_mask_reg    <= (weight_mode == MODE_REAL || weight_mode == MODE_COMPL) &&
                               (32'(wavelength) < WAVELENGTHS);
            resp_status_reg <= (a_bad || b_bad) ? ST_NO_PATH : ST_STORE_FULL;
            resp_index_reg  <= '0;
        end
        if (state_reg == S_ADD_A_WR)
        begin
            resp_status_reg <= ST_PAIR_ADDED;
            resp_index_reg  <= IndexW'(ec_reg);
        end
        if (state_reg == S_Q_INIT)
        begin
            front_reg <= '0;
            tail_reg  <= NW'(1);
            size_reg  <= (NW + 1)'(1);
        end
        if (state_reg == S_Q_HEAD)
        begin
            u_reg     <= queue_rdata;
            front_reg <= (32'(front_reg) == NODE_COUNT - 1) ? '0 : front_reg + 1'b1;
            size_reg  <= size_reg - 1'b1;
        end
        if (state_reg == S_Q_HEADW)
        begin
            e_reg    <= head_rdata;
            more_reg <= hvalid_reg[u_reg];
            du_reg   <= dist_rdata;
        end
        if (state_reg == S_Q_EDGEW)
        begin
            ok_reg   <= !(use_mask_reg && ((mask_rdata & bit_reg) != '0));
            nd_reg   <= du_reg + 32'(cost);
            to_reg   <= rd_to;
            next_reg <= rd_next;
            nv_reg   <= rd_nv;
        end
        if (state_reg == S_Q_RELAX)
        begin
            e_reg    <= next_reg;
            more_reg <= nv_reg;
            if (relax && !inq_reg[to_reg])
            begin
                tail_reg <= (32'(tail_reg) == NODE_COUNT - 1) ? '0 : tail_reg + 1'b1;
                size_reg <= size_reg + 1'b1;
            end
        end
        if (state_reg == S_Q_DONE)
        begin
            resp_status_reg <= dvalid_reg[nb_reg] ? ST_EMPTY_PATH : ST_NO_PATH;
            resp_index_reg  <= '0;
            n_reg           <= nb_reg;
            cnt_reg         <= '0;
            i_reg           <= '0;
        end
        if (state_reg == S_P_FROM)
        begin
            cnt_reg <= cnt_inc;
            n_reg   <= n_step;
        end
        if (state_reg == S_P_NEXT)
        begin
            n_reg <= rd_from;
        end
        if ((state_reg == S_E_SEND) && out_free)
        begin
            i_reg <= i_reg + 1'b1;
        end
        if (load_out)
        begin
            status_reg     <= load_status;
            edge_index_reg <= load_index;
            last_reg       <= load_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign edge_index = edge_index_reg;
    assign last       = last_reg;

endmodule
